// ===== rtl/lsls_pkg.sv =====
`default_nettype none
package lsls_pkg;

  // Field widths fixed by the request and result formats.
  localparam int STOP_W = 4;
  localparam int NSTOPS = 16;
  localparam int SCNT_W = $clog2(NSTOPS + 1);
  localparam int POS_W  = 24;
  localparam int OWN_W  = 16;
  localparam int TICK_W = 32;
  localparam int CLS_W  = 2;
  localparam int DIR_W  = 2;
  localparam int STAT_W = 2;
  localparam int REQ_W  = 2;
  localparam int CNT_W  = 5;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_ADD    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CHOOSE = 2'd2;
  localparam logic [REQ_W-1:0] REQ_LOAD   = 2'd3;

  // Travel directions and owner classes share the same coding.
  localparam logic [DIR_W-1:0] DIR_NONE = 2'd0;
  localparam logic [DIR_W-1:0] DIR_UP   = 2'd1;
  localparam logic [DIR_W-1:0] DIR_DOWN = 2'd2;

  // Status codes.
  localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STAT_W-1:0] ST_IGNORED = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;

  // One stored stop request.
  typedef struct packed {
    logic [STOP_W-1:0] stop;
    logic [OWN_W-1:0]  owner;
    logic [TICK_W-1:0] tick;
    logic [CLS_W-1:0]  cls;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

endpackage
`default_nettype wire

// ===== rtl/lsls_in_if.sv =====
`default_nettype none
interface lsls_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [3:0]  stop_index;
  logic [15:0] owner_id;
  logic [31:0] request_tick;
  logic [1:0]  owner_class;
  logic signed [23:0] car_position;
  logic [4:0]  standing_stop;
  logic signed [23:0] stop_position;

  modport source (output valid, req_type, stop_index, owner_id, request_tick,
                  owner_class, car_position, standing_stop, stop_position,
                  input ready);
  modport sink (input valid, req_type, stop_index, owner_id, request_tick,
                owner_class, car_position, standing_stop, stop_position,
                output ready);
endinterface
`default_nettype wire

// ===== rtl/lsls_out_if.sv =====
`default_nettype none
interface lsls_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] chosen_stop;
  logic       found;
  logic [1:0] travel_direction;
  logic [1:0] status;

  modport source (output valid, chosen_stop, found, travel_direction, status,
                  input ready);
  modport sink (input valid, chosen_stop, found, travel_direction, status,
                output ready);
endinterface
`default_nettype wire

// ===== rtl/lsls_cfg_if.sv =====
`default_nettype none
interface lsls_cfg_if;
  logic       valid;
  logic       ready;
  logic [4:0] stops_in_use;

  modport source (output valid, stops_in_use, input ready);
  modport sink (input valid, stops_in_use, output ready);
endinterface
`default_nettype wire

// ===== rtl/look_lift_stop_scheduler.sv =====
`default_nettype none
// LOOK lift stop scheduler. A request table in RAM holds (stop, owner, tick,
// class) records, and a small RAM holds stop positions. Load writes the
// position RAM as the request is accepted and goes straight to the final step.
// Add and remove walk the table through its single read port, one entry per
// cycle, plus a pipeline drain and a final step. Choose walks the table once to
// gather per-stop flags and oldest ticks, then walks the 16 stops through the
// position RAM read port, judging the current-direction, reverse and
// oldest-tick candidates together. One request is handled at a time; the next
// is taken once the previous result has moved into the output register, so a
// result beat that the receiver has not yet taken holds the final step and
// stalls the input.
module look_lift_stop_scheduler #(
  parameter int TABLE_ENTRIES = 64
) (
  input wire logic clk,
  input wire logic rst_n,
  lsls_in_if.sink    in_ch,
  lsls_out_if.source out_ch,
  lsls_cfg_if.sink   cfg_ch
);
  import lsls_pkg::*;

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int CW = $clog2(TABLE_ENTRIES + 1);

  typedef enum logic [1:0] {S_IDLE, S_TSCAN, S_SSCAN, S_FIN} state_t;

  state_t state_r;

  // Captured request.
  logic [REQ_W-1:0]  req_r;
  logic [STOP_W-1:0] stop_r;
  logic [OWN_W-1:0]  owner_r;
  logic [TICK_W-1:0] tick_r;
  logic [CLS_W-1:0]  cls_r;
  logic signed [POS_W-1:0] car_r;
  logic [4:0]        standing_r;
  logic              ign_r;

  logic [CNT_W-1:0]  stops_in_use_r;
  logic [DIR_W-1:0]  dir_r;
  logic [TABLE_ENTRIES-1:0] valid_r;

  // Table walk.
  logic [CW-1:0] cnt_r;
  logic          pv_r;
  logic [AW-1:0] idx_r;
  logic          dup_r;
  logic          free_found_r;
  logic [AW-1:0] free_idx_r;

  // Per-stop summary built by the table walk.
  logic [NSTOPS-1:0] has_up_r;
  logic [NSTOPS-1:0] has_dn_r;
  logic [TICK_W-1:0] oldest_r [NSTOPS];

  // Stop walk and candidates.
  logic [SCNT_W-1:0] scnt_r;
  logic              spv_r;
  logic [STOP_W-1:0] sidx_r;
  logic              up_f_r, dn_f_r, od_f_r;
  logic [STOP_W-1:0] up_s_r, dn_s_r, od_s_r;
  logic [POS_W:0]    up_d_r, dn_d_r, od_d_r;
  logic [TICK_W-1:0] od_t_r;
  logic [DIR_W-1:0]  od_dir_r;

  // Output register.
  logic              out_valid_r;
  logic [STOP_W-1:0] out_chosen_r;
  logic              out_found_r;
  logic [DIR_W-1:0]  out_dir_r;
  logic [STAT_W-1:0] out_status_r;

  // Memories.
  rec_t              rec_rd;
  logic [REC_W-1:0]  rec_rd_bits;
  logic              tab_we;
  rec_t              tab_wdata;
  logic [POS_W-1:0]  pos_rd;
  logic              pos_we;

  logic [CNT_W-1:0]  served;
  logic              in_acc;

  assign served = (stops_in_use_r > CNT_W'(NSTOPS)) ? CNT_W'(NSTOPS) : stops_in_use_r;
  assign in_acc = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid            = out_valid_r;
  assign out_ch.chosen_stop      = out_chosen_r;
  assign out_ch.found            = out_found_r;
  assign out_ch.travel_direction = out_dir_r;
  assign out_ch.status           = out_status_r;

  assign rec_rd = rec_t'(rec_rd_bits);
  assign tab_we = (state_r == S_FIN) && (req_r == REQ_ADD) && !ign_r && !dup_r
                  && free_found_r && (!out_valid_r || out_ch.ready);
  assign tab_wdata = '{stop: stop_r, owner: owner_r, tick: tick_r, cls: cls_r};
  assign pos_we = in_acc && (in_ch.req_type == REQ_LOAD);

  lsls_ram #(.WIDTH(REC_W), .DEPTH(TABLE_ENTRIES)) u_tab (
    .clk   (clk),
    .we    (tab_we),
    .waddr (free_idx_r),
    .wdata (tab_wdata),
    .raddr (cnt_r[AW-1:0]),
    .rdata (rec_rd_bits)
  );

  lsls_ram #(.WIDTH(POS_W), .DEPTH(NSTOPS)) u_pos (
    .clk   (clk),
    .we    (pos_we),
    .waddr (in_ch.stop_index),
    .wdata (in_ch.stop_position),
    .raddr (scnt_r[STOP_W-1:0]),
    .rdata (pos_rd)
  );

  // Evaluation of the table entry whose record is on the read port.
  logic v_cur, match_cur, any_cur;
  always_comb begin
    v_cur     = valid_r[idx_r];
    match_cur = (rec_rd.stop == stop_r) && (rec_rd.owner == owner_r);
    any_cur   = has_up_r[rec_rd.stop] | has_dn_r[rec_rd.stop];
  end

  // Evaluation of the stop whose position is on the read port.
  logic signed [POS_W:0] delta;
  logic [POS_W:0]        abs_d;
  logic                  s_ok, up_take, dn_take, od_take;
  logic [DIR_W-1:0]      s_dir;
  always_comb begin
    delta = $signed({pos_rd[POS_W-1], pos_rd}) - $signed({car_r[POS_W-1], car_r});
    abs_d = delta[POS_W] ? (POS_W+1)'(-delta) : delta;
    s_ok  = ({1'b0, sidx_r} < served);
    s_dir = (delta > 0) ? DIR_UP : ((delta < 0) ? DIR_DOWN : DIR_NONE);
    up_take = s_ok && ({1'b0, sidx_r} != standing_r) && has_up_r[sidx_r] && (delta > 0)
              && (!up_f_r || abs_d < up_d_r);
    dn_take = s_ok && ({1'b0, sidx_r} != standing_r) && has_dn_r[sidx_r] && (delta < 0)
              && (!dn_f_r || abs_d < dn_d_r);
    od_take = s_ok && (has_up_r[sidx_r] | has_dn_r[sidx_r])
              && (!od_f_r || oldest_r[sidx_r] < od_t_r
                  || (oldest_r[sidx_r] == od_t_r && abs_d < od_d_r));
  end

  // Final choice of the LOOK step.
  logic              ch_found;
  logic [STOP_W-1:0] ch_stop;
  logic [DIR_W-1:0]  ch_dir;
  always_comb begin
    ch_found = 1'b0;
    ch_stop  = '0;
    ch_dir   = dir_r;
    if (dir_r == DIR_UP && up_f_r) begin
      ch_found = 1'b1; ch_stop = up_s_r; ch_dir = DIR_UP;
    end else if (dir_r == DIR_UP && dn_f_r) begin
      ch_found = 1'b1; ch_stop = dn_s_r; ch_dir = DIR_DOWN;
    end else if (dir_r == DIR_DOWN && dn_f_r) begin
      ch_found = 1'b1; ch_stop = dn_s_r; ch_dir = DIR_DOWN;
    end else if (dir_r == DIR_DOWN && up_f_r) begin
      ch_found = 1'b1; ch_stop = up_s_r; ch_dir = DIR_UP;
    end else if (od_f_r) begin
      ch_found = 1'b1; ch_stop = od_s_r; ch_dir = od_dir_r;
    end
  end

  // Sequencer, table state and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      stops_in_use_r <= CNT_W'(NSTOPS);
      dir_r          <= DIR_NONE;
      valid_r        <= '0;
      out_valid_r    <= 1'b0;
      pv_r           <= 1'b0;
      spv_r          <= 1'b0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        stops_in_use_r <= cfg_ch.stops_in_use;
      end
      // The final step reloads the output register itself.
      if (out_valid_r && out_ch.ready && (state_r != S_FIN)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            req_r      <= in_ch.req_type;
            stop_r     <= in_ch.stop_index;
            owner_r    <= in_ch.owner_id;
            tick_r     <= in_ch.request_tick;
            cls_r      <= in_ch.owner_class;
            car_r      <= in_ch.car_position;
            standing_r <= in_ch.standing_stop;
            ign_r      <= (in_ch.owner_id == '0) || ({1'b0, in_ch.stop_index} >= served);
            cnt_r        <= '0;
            pv_r         <= 1'b0;
            dup_r        <= 1'b0;
            free_found_r <= 1'b0;
            has_up_r     <= '0;
            has_dn_r     <= '0;
            if (in_ch.req_type == REQ_LOAD) begin
              state_r <= S_FIN;
            end else begin
              state_r <= S_TSCAN;
            end
          end
        end
        S_TSCAN: begin
          // Issue the next table read while judging the previous one.
          if (cnt_r < CW'(TABLE_ENTRIES)) begin
            pv_r  <= 1'b1;
            idx_r <= cnt_r[AW-1:0];
            cnt_r <= cnt_r + 1'b1;
          end else begin
            pv_r <= 1'b0;
          end
          if (pv_r) begin
            case (req_r)
              REQ_ADD: begin
                if (v_cur && match_cur) begin
                  dup_r <= 1'b1;
                end
                if (!v_cur && !free_found_r) begin
                  free_found_r <= 1'b1;
                  free_idx_r   <= idx_r;
                end
              end
              REQ_REMOVE: begin
                if (v_cur && match_cur && !ign_r) begin
                  valid_r[idx_r] <= 1'b0;
                end
              end
              REQ_CHOOSE: begin
                if (v_cur) begin
                  if (rec_rd.cls != DIR_DOWN) begin
                    has_up_r[rec_rd.stop] <= 1'b1;
                  end
                  if (rec_rd.cls != DIR_UP) begin
                    has_dn_r[rec_rd.stop] <= 1'b1;
                  end
                  if (!any_cur || rec_rd.tick < oldest_r[rec_rd.stop]) begin
                    oldest_r[rec_rd.stop] <= rec_rd.tick;
                  end
                end
              end
              default: begin
              end
            endcase
          end
          if (cnt_r == CW'(TABLE_ENTRIES) && !pv_r) begin
            scnt_r <= '0;
            spv_r  <= 1'b0;
            up_f_r <= 1'b0;
            dn_f_r <= 1'b0;
            od_f_r <= 1'b0;
            state_r <= (req_r == REQ_CHOOSE) ? S_SSCAN : S_FIN;
          end
        end
        S_SSCAN: begin
          // Walk the stops, one position read per cycle.
          if (scnt_r < SCNT_W'(NSTOPS)) begin
            spv_r  <= 1'b1;
            sidx_r <= scnt_r[STOP_W-1:0];
            scnt_r <= scnt_r + 1'b1;
          end else begin
            spv_r <= 1'b0;
          end
          if (spv_r) begin
            if (up_take) begin
              up_f_r <= 1'b1; up_s_r <= sidx_r; up_d_r <= abs_d;
            end
            if (dn_take) begin
              dn_f_r <= 1'b1; dn_s_r <= sidx_r; dn_d_r <= abs_d;
            end
            if (od_take) begin
              od_f_r   <= 1'b1;
              od_s_r   <= sidx_r;
              od_d_r   <= abs_d;
              od_t_r   <= oldest_r[sidx_r];
              od_dir_r <= s_dir;
            end
          end
          if (scnt_r == SCNT_W'(NSTOPS) && !spv_r) begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          // Hand the result to the output register once it is free.
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r  <= 1'b1;
            out_chosen_r <= '0;
            out_found_r  <= 1'b0;
            out_dir_r    <= dir_r;
            out_status_r <= ST_DONE;
            case (req_r)
              REQ_ADD: begin
                if (ign_r || dup_r) begin
                  out_status_r <= ST_IGNORED;
                end else if (!free_found_r) begin
                  out_status_r <= ST_FULL;
                end else begin
                  valid_r[free_idx_r] <= 1'b1;
                end
              end
              REQ_REMOVE: begin
                if (ign_r) begin
                  out_status_r <= ST_IGNORED;
                end
              end
              REQ_CHOOSE: begin
                out_chosen_r <= ch_stop;
                out_found_r  <= ch_found;
                out_dir_r    <= ch_dir;
                dir_r        <= ch_dir;
              end
              default: begin
              end
            endcase
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/lsls_ram.sv =====
`default_nettype none
module lsls_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire
